@@ hdl/assert_macros.svh @@
// Assertion macros shared by the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define BTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hdl/btc_pkg.sv @@
// Shared constants, codes and types of the frame track classifier.
package btc_pkg;

	localparam int MAX_ROWS      = 60;
	localparam int BYTES_PER_ROW = 10;
	localparam int LANES         = 8;
	localparam int CARRY_W       = 2;
	localparam int BYTE_W        = 8;
	localparam int BIR_W         = 4;
	localparam int ROW_W         = $clog2(MAX_ROWS + 1);
	localparam int COL_W         = 7;
	localparam int CNT_W         = 11;
	localparam int BAL_W         = 14;
	localparam int THR_W         = 13;
	localparam int RU_W          = 6;
	localparam int PCNT_W        = $clog2(LANES + 1);
	localparam int CFG_IDX_W     = 8;
	localparam int CFG_DATA_W    = 13;

	localparam int SPLIT_COL  = 40;
	localparam int CENTRE_LO  = 25;
	localparam int CENTRE_HI  = 55;
	localparam int OUTER_LO   = 15;
	localparam int OUTER_HI   = 65;
	localparam int TURN_RESET = 150;
	localparam int ROWS_RESET = 15;
	localparam int CNT_MAX    = 2047;
	localparam int BAL_MAX    = 8191;
	localparam int BAL_MIN    = -8192;

	localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED      = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		TRK_LEFT     = 3'd0,
		TRK_RIGHT    = 3'd1,
		TRK_ROUND    = 3'd2,
		TRK_STRAIGHT = 3'd3,
		TRK_CROSS    = 3'd4
	} track_t;

	// What one filtered pixel contributes to the frame counters.
	typedef struct packed {
		logic neg;
		logic pos;
		logic cset;
		logic oset;
		logic cclr;
		logic oclr;
	} lane_hit_t;

	typedef struct packed {
		logic signed [BAL_W-1:0] bal;
		logic [CNT_W-1:0]        cset;
		logic [CNT_W-1:0]        cclr;
		logic [CNT_W-1:0]        oset;
		logic [CNT_W-1:0]        oclr;
	} frame_sums_t;

endpackage

@@ hdl/btc_lane.sv @@
// One pixel lane: majority filter and band decode for a single column.
module btc_lane (
	input  logic [2:0]                   nbhd,
	input  logic [btc_pkg::COL_W-1:0]    col,
	input  logic                         en,
	output btc_pkg::lane_hit_t           hit
);
	import btc_pkg::*;

	logic maj;
	logic left_half;
	logic centre;
	logic outer_s;
	logic outer_c;

	always_comb begin
		maj       = (nbhd[2] & nbhd[1]) | (nbhd[2] & nbhd[0]) | (nbhd[1] & nbhd[0]);
		left_half = col < COL_W'(SPLIT_COL);
		centre    = (col > COL_W'(CENTRE_LO)) && (col < COL_W'(CENTRE_HI));
		// The right outer band starts one column later for clear pixels.
		outer_s   = (col < COL_W'(OUTER_LO)) || (col >= COL_W'(OUTER_HI));
		outer_c   = (col < COL_W'(OUTER_LO)) || (col > COL_W'(OUTER_HI));

		hit.neg  = en & maj & left_half;
		hit.pos  = en & maj & ~left_half;
		hit.cset = en & maj & centre;
		hit.oset = en & maj & outer_s;
		hit.cclr = en & ~maj & centre;
		hit.oclr = en & ~maj & outer_c;
	end

endmodule

@@ hdl/btc_merge.sv @@
// Merge stage: sums the lane hits into the frame counters and holds the final sums.
module btc_merge (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       step,
	input  logic                                       last,
	input  btc_pkg::lane_hit_t [btc_pkg::LANES-1:0]    hits,
	input  logic                                       take,
	output btc_pkg::frame_sums_t                       sums,
	output logic                                       sums_valid
);
	import btc_pkg::*;

	logic signed [BAL_W-1:0] bal_q;
	logic [CNT_W-1:0]        cset_q;
	logic [CNT_W-1:0]        cclr_q;
	logic [CNT_W-1:0]        oset_q;
	logic [CNT_W-1:0]        oclr_q;

	logic [PCNT_W-1:0] n_neg, n_pos, n_cset, n_oset, n_cclr, n_oclr;
	logic signed [BAL_W+1:0] bal_wide;
	frame_sums_t nxt;
	frame_sums_t sums_q;
	logic        sums_valid_q;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
	                                             input logic [PCNT_W-1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, c} + (CNT_W + 1)'(n);
		return (s > (CNT_W + 1)'(CNT_MAX)) ? CNT_W'(CNT_MAX) : s[CNT_W-1:0];
	endfunction

	always_comb begin
		n_neg  = '0;
		n_pos  = '0;
		n_cset = '0;
		n_oset = '0;
		n_cclr = '0;
		n_oclr = '0;
		for (int i = 0; i < LANES; i++) begin
			n_neg  = n_neg  + PCNT_W'(hits[i].neg);
			n_pos  = n_pos  + PCNT_W'(hits[i].pos);
			n_cset = n_cset + PCNT_W'(hits[i].cset);
			n_oset = n_oset + PCNT_W'(hits[i].oset);
			n_cclr = n_cclr + PCNT_W'(hits[i].cclr);
			n_oclr = n_oclr + PCNT_W'(hits[i].oclr);
		end

		bal_wide = (BAL_W + 2)'(bal_q) + (BAL_W + 2)'(n_pos) - (BAL_W + 2)'(n_neg);
		if (bal_wide > BAL_MAX) begin
			nxt.bal = BAL_W'(BAL_MAX);
		end else if (bal_wide < BAL_MIN) begin
			nxt.bal = BAL_W'(BAL_MIN);
		end else begin
			nxt.bal = bal_wide[BAL_W-1:0];
		end
		nxt.cset = sat_add(cset_q, n_cset);
		nxt.cclr = sat_add(cclr_q, n_cclr);
		nxt.oset = sat_add(oset_q, n_oset);
		nxt.oclr = sat_add(oclr_q, n_oclr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q  <= '0;
			cset_q <= '0;
			cclr_q <= '0;
			oset_q <= '0;
			oclr_q <= '0;
		end else if (step) begin
			if (last) begin
				bal_q  <= '0;
				cset_q <= '0;
				cclr_q <= '0;
				oset_q <= '0;
				oclr_q <= '0;
			end else begin
				bal_q  <= nxt.bal;
				cset_q <= nxt.cset;
				cclr_q <= nxt.cclr;
				oset_q <= nxt.oset;
				oclr_q <= nxt.oclr;
			end
		end
	end

	// The final sums of a frame wait here until the output register takes them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_valid_q <= 1'b0;
		end else if (step && last) begin
			sums_valid_q <= 1'b1;
		end else if (take) begin
			sums_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last) begin
			sums_q <= nxt;
		end
	end

	assign sums       = sums_q;
	assign sums_valid = sums_valid_q;

endmodule

@@ hdl/binary_frame_track_classifier.sv @@
// Top level of the binary frame track classifier: position tracking, lanes and result register.
//
// Usage: a packed 1-bit frame enters on the byte channel (byte_valid, byte_stall,
// pixel_byte, frame_last), ten bytes per 80-pixel row, bit 7 leftmost. A transfer
// happens at a rising edge with byte_valid high and byte_stall low. While byte_stall is
// low, one byte is taken every cycle; eight pixel lanes filter and decode the eight columns
// that the byte completes, and a merge stage adds their hits to the frame counters.
// The byte that carries frame_last yields one result on the result channel
// (result_valid, result_stall, track_type, balance, round_count, cross_count) through
// the s1, merge and output registers; no other byte yields a result. The counters and the
// row position clear with that byte, so the next frame may follow at once.
// While result_stall holds a result, one more frame's final sums can wait in the
// merge stage; only a further final byte then raises byte_stall, every other byte
// still flows. Configuration (turn_threshold index 0, rows_used index 1) is written
// through cfg_valid/cfg_ready, always ready. It must be written only while the block
// is idle; the block itself does not enforce this. Reset clears all counters, the row
// position and the result channel, and loads the threshold with 150 and rows_used with 15.
`include "assert_macros.svh"

module binary_frame_track_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               byte_valid,
	output logic                               byte_stall,
	input  logic [btc_pkg::BYTE_W-1:0]         pixel_byte,
	input  logic                               frame_last,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [2:0]                         track_type,
	output logic signed [btc_pkg::BAL_W-1:0]   balance,
	output logic [btc_pkg::CNT_W-1:0]          round_count,
	output logic [btc_pkg::CNT_W-1:0]          cross_count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [btc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [btc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import btc_pkg::*;

	logic [THR_W-1:0]   thr_q;
	logic [RU_W-1:0]    rows_q;
	logic [CARRY_W-1:0] carry_q;
	logic [BIR_W-1:0]   bir_q;
	logic [ROW_W-1:0]   row_q;

	lane_hit_t [LANES-1:0] hits;
	lane_hit_t [LANES-1:0] hits_s1;
	logic                  valid_s1;
	logic                  last_s1;

	frame_sums_t sums;
	logic        sums_valid;

	logic               accept;
	logic               row_ok;
	logic [COL_W-1:0]   col_base;
	logic [CARRY_W+BYTE_W-1:0] win;
	logic               out_free;
	logic               take;
	logic               sums_free;
	logic               s1_go;

	logic               out_valid_q;
	track_t             type_q;
	logic signed [BAL_W-1:0] bal_q;
	logic [CNT_W-1:0]   round_q;
	logic [CNT_W-1:0]   cross_q;

	logic [BAL_W-1:0]   mag;
	track_t             type_nx;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_W'(TURN_RESET);
			rows_q <= RU_W'(ROWS_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TURN_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				REG_ROWS_USED:      rows_q <= cfg_data[RU_W-1:0];
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// Flow control. Only a final byte needs room in the merge stage's result hold.
	assign out_free   = !out_valid_q || !result_stall;
	assign take       = sums_valid && out_free;
	assign sums_free  = !sums_valid || take;
	assign s1_go      = valid_s1 && (!last_s1 || sums_free);
	assign byte_stall = valid_s1 && !s1_go;
	assign accept     = byte_valid && !byte_stall;

	// Position in the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			bir_q   <= '0;
			row_q   <= '0;
		end else if (accept) begin
			if (frame_last) begin
				carry_q <= '0;
				bir_q   <= '0;
				row_q   <= '0;
			end else begin
				carry_q <= pixel_byte[CARRY_W-1:0];
				if (bir_q == BIR_W'(BYTES_PER_ROW - 1)) begin
					bir_q <= '0;
					if (row_q < ROW_W'(MAX_ROWS)) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					bir_q <= bir_q + 1'b1;
				end
			end
		end
	end

	assign row_ok   = (32'(row_q) < 32'(rows_q)) && (32'(row_q) < 32'(MAX_ROWS));
	assign col_base = {bir_q, 3'b000};
	// Window bit 9 is two columns left of the byte, bit 0 its rightmost pixel.
	assign win      = {carry_q, pixel_byte};

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		localparam bit EDGE_LANE = (j < CARRY_W);
		logic en;
		logic [COL_W-1:0] col;

		// At the start of a row the first two lanes are off: their windows reach the carried pixels.
		assign en  = row_ok && (!EDGE_LANE || (bir_q != '0));
		assign col = col_base + COL_W'(j) - COL_W'(1);

		btc_lane u_lane (
			.nbhd (win[CARRY_W+BYTE_W-1-j -: 3]),
			.col  (col),
			.en   (en),
			.hit  (hits[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hits_s1 <= hits;
			last_s1 <= frame_last;
		end
	end

	btc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.last       (last_s1),
		.hits       (hits_s1),
		.take       (take),
		.sums       (sums),
		.sums_valid (sums_valid)
	);

	// Classification of the final sums.
	always_comb begin
		mag = sums.bal[BAL_W-1] ? BAL_W'(-sums.bal) : sums.bal;
		priority if (mag > BAL_W'(thr_q)) begin
			type_nx = (sums.bal > 0) ? TRK_LEFT : TRK_RIGHT;
		end else if (sums.cset > sums.cclr) begin
			type_nx = TRK_ROUND;
		end else if (sums.oset > sums.oclr) begin
			type_nx = TRK_STRAIGHT;
		end else begin
			type_nx = TRK_CROSS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= sums_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_q  <= type_nx;
			bal_q   <= sums.bal;
			round_q <= sums.cset;
			cross_q <= sums.oset;
		end
	end

	assign result_valid = out_valid_q;
	assign track_type   = type_q;
	assign balance      = bal_q;
	assign round_count  = round_q;
	assign cross_count  = cross_q;

	`BTC_ASSERT_IMP(a_stall_only_final, clk, arst_n, byte_stall, valid_s1 && last_s1)
	`BTC_ASSERT_NXT(a_final_clears_pos, clk, arst_n, accept && frame_last,
		(bir_q == '0) && (row_q == '0))
	`BTC_ASSERT_IMP(a_byte_pos_range, clk, arst_n, 1'b1, bir_q < BIR_W'(BYTES_PER_ROW))
	`BTC_ASSERT_IMP(a_row_range, clk, arst_n, 1'b1, row_q <= ROW_W'(MAX_ROWS))

endmodule

@@ tb/binary_frame_track_classifier_tb.sv @@
// Self-checking testbench for the binary frame track classifier.
module binary_frame_track_classifier_tb;
	import btc_pkg::*;

	typedef struct {
		track_t                  kind;
		logic signed [BAL_W-1:0] bal;
		logic [CNT_W-1:0]        round_n;
		logic [CNT_W-1:0]        cross_n;
	} verdict_t;

	typedef enum int {
		PAT_NOISE, PAT_DENSE, PAT_SPARSE, PAT_LEFT, PAT_RIGHT, PAT_OUTER, PAT_CENTRE
	} pattern_t;

	// Tracks the frame counters and holds the track verdicts still owed by the block.
	class track_ledger;
		logic [THR_W-1:0] threshold;
		logic [RU_W-1:0]  rows_cfg;
		logic [1:0]       carry;
		int               byte_pos, row, bal, cset, cclr, oset, oclr;
		verdict_t         due[$];
		int               mismatches, bytes_taken, verdicts_seen;

		function new();
			threshold = THR_W'(TURN_RESET);
			rows_cfg = RU_W'(ROWS_RESET);
			mismatches = 0;
			bytes_taken = 0;
			verdicts_seen = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			carry = 2'b00;
			byte_pos = 0;
			row = 0;
			bal = 0;
			cset = 0;
			cclr = 0;
			oset = 0;
			oclr = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_TURN_THRESHOLD) threshold = data[THR_W-1:0];
			else if (idx == REG_ROWS_USED) rows_cfg = data[RU_W-1:0];
		endfunction

		function int bump(int n);
			return (n < CNT_MAX) ? n + 1 : n;
		endfunction

		function void tally_pixel(int col, bit is_set);
			if (is_set) begin
				if (col < SPLIT_COL) begin
					if (bal > BAL_MIN) bal--;
					if (col > CENTRE_LO) cset = bump(cset);
					else if (col < OUTER_LO) oset = bump(oset);
				end else begin
					if (bal < BAL_MAX) bal++;
					if (col < CENTRE_HI) cset = bump(cset);
					else if (col >= OUTER_HI) oset = bump(oset);
				end
			end else if (col > CENTRE_LO && col < CENTRE_HI) begin
				cclr = bump(cclr);
			end else if (col < OUTER_LO || col > OUTER_HI) begin
				// A clear pixel in the column just at the outer edge is not counted.
				oclr = bump(oclr);
			end
		endfunction

		function void take_byte(logic [BYTE_W-1:0] px, logic last);
			logic [9:0] win;
			int         first, pos, ones, mag;
			verdict_t   v;
			bytes_taken++;
			if (row < int'(rows_cfg) && row < MAX_ROWS) begin
				// The window spans the two carried pixels and the new byte.
				win = {carry, px};
				first = (byte_pos == 0) ? 3 : 1;
				for (int k = first; k <= 8; k++) begin
					pos = 9 - k;
					ones = int'(win[pos+1]) + int'(win[pos]) + int'(win[pos-1]);
					tally_pixel(byte_pos * 8 + k - 2, ones >= 2);
				end
			end
			carry = px[1:0];
			byte_pos++;
			if (byte_pos >= BYTES_PER_ROW) begin
				byte_pos = 0;
				if (row < MAX_ROWS) row++;
			end
			if (last) begin
				mag = (bal < 0) ? -bal : bal;
				if (mag > int'(threshold)) v.kind = (bal > 0) ? TRK_LEFT : TRK_RIGHT;
				else if (cset > cclr) v.kind = TRK_ROUND;
				else if (oset > oclr) v.kind = TRK_STRAIGHT;
				else v.kind = TRK_CROSS;
				v.bal = BAL_W'(bal);
				v.round_n = CNT_W'(cset);
				v.cross_n = CNT_W'(oset);
				due.push_back(v);
				clear_frame();
			end
		endfunction

		function void match_verdict(logic [2:0] kind, logic signed [BAL_W-1:0] bal_got,
				logic [CNT_W-1:0] round_got, logic [CNT_W-1:0] cross_got);
			verdict_t v;
			verdicts_seen++;
			if (due.size() == 0) begin
				$error("result with no frame awaiting it: track_type %0d, balance %0d",
					kind, bal_got);
				mismatches++;
				return;
			end
			v = due.pop_front();
			if (kind !== v.kind) begin
				$error("track_type: expected %0d, got %0d", v.kind, kind);
				mismatches++;
			end
			if (bal_got !== v.bal) begin
				$error("balance: expected %0d, got %0d", v.bal, bal_got);
				mismatches++;
			end
			if (round_got !== v.round_n) begin
				$error("round_count: expected %0d, got %0d", v.round_n, round_got);
				mismatches++;
			end
			if (cross_got !== v.cross_n) begin
				$error("cross_count: expected %0d, got %0d", v.cross_n, cross_got);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  byte_valid;
	logic                  byte_stall;
	logic [BYTE_W-1:0]     pixel_byte;
	logic                  frame_last;
	logic                  result_valid;
	logic                  result_stall;
	logic [2:0]            track_type;
	logic signed [BAL_W-1:0] balance;
	logic [CNT_W-1:0]      round_count;
	logic [CNT_W-1:0]      cross_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	track_ledger ledger;
	bit          calm;
	int          frames_sent;
	int          settings_applied;

	binary_frame_track_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.pixel_byte(pixel_byte),
		.frame_last(frame_last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.track_type(track_type),
		.balance(balance),
		.round_count(round_count),
		.cross_count(cross_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [BYTE_W-1:0] pattern_byte(pattern_t pat, int col_byte);
		logic [BYTE_W-1:0] b;
		case (pat)
			PAT_NOISE: b = 8'($urandom_range(0, 255));
			PAT_DENSE: b = 8'($urandom | $urandom);
			PAT_SPARSE: b = 8'($urandom & $urandom & $urandom);
			PAT_LEFT: b = (col_byte < 5) ? 8'hFF : 8'h00;
			PAT_RIGHT: b = (col_byte >= 5) ? 8'hFF : 8'h00;
			PAT_OUTER: b = (col_byte < 2 || col_byte > 7) ? 8'hFF : 8'h00;
			default: b = (col_byte >= 3 && col_byte <= 6) ? 8'hFF : 8'h00;
		endcase
		// Speckle the banded patterns so that the majority filter has work to do.
		if (pat >= PAT_LEFT && $urandom_range(0, 5) == 0) b ^= 8'(1 << $urandom_range(0, 7));
		return b;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [BYTE_W-1:0] px, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			byte_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid = 1'b1;
		pixel_byte = px;
		frame_last = last;
		do @(posedge clk); while (byte_stall);
		ledger.take_byte(px, last);
		if (last) frames_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int nbytes, input pattern_t pat);
		for (int i = 0; i < nbytes; i++)
			send_byte(pattern_byte(pat, i % BYTES_PER_ROW), i == nbytes - 1);
	endtask

	// Lets the block drain: every verdict back, then a wait for bytes in flight.
	task automatic wait_idle();
		byte_valid = 1'b0;
		while (ledger.due.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic apply_setting(input int thr, input int rows);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = REG_TURN_THRESHOLD;
		cfg_data = CFG_DATA_W'(thr);
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(cfg_index, cfg_data);
		@(negedge clk);
		cfg_index = REG_ROWS_USED;
		cfg_data = CFG_DATA_W'(rows);
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(cfg_index, cfg_data);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_applied++;
	endtask

	// Mostly whole-row frames with random content; the rest hold 1 to 25 bytes.
	task automatic run_phase(input int thr, input int rows, input int budget);
		int sent, nbytes, span;
		apply_setting(thr, rows);
		span = (rows < 1) ? 1 : ((rows > 3) ? 3 : rows);
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 7) == 0) calm = ~calm;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: nbytes = BYTES_PER_ROW * $urandom_range(1, span + 1);
				6, 7, 8: nbytes = $urandom_range(1, 25);
				default: nbytes = BYTES_PER_ROW * $urandom_range(1, 6);
			endcase
			send_frame(nbytes, pattern_t'($urandom_range(0, 6)));
			sent += nbytes;
		end
	endtask

	function automatic int pick_threshold();
		return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 100) : $urandom_range(0, 4680);
	endfunction

	initial begin : result_side
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 16);
			if (hold > 0) begin
				@(negedge clk);
				result_stall = 1'b1;
				repeat (hold) @(negedge clk);
				result_stall = 1'b0;
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
			ledger.match_verdict(track_type, balance, round_count, cross_count);
		end
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] straight_row [10];
		logic [BYTE_W-1:0] mixed_bytes [4];
		straight_row = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
		mixed_bytes = '{8'h81, 8'h7E, 8'hAA, 8'h55};
		ledger = new();
		calm = 1'b0;
		frames_sent = 0;
		settings_applied = 0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		pixel_byte = '0;
		frame_last = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TURN_THRESHOLD;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: one-byte frames, a full set row, bands at the edges, a mixed tail.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		for (int i = 0; i < BYTES_PER_ROW; i++) send_byte(8'hFF, i == BYTES_PER_ROW - 1);
		foreach (straight_row[i]) send_byte(straight_row[i], i == 9);
		foreach (mixed_bytes[i]) send_byte(mixed_bytes[i], i == 3);

		// Zero threshold: left half alone, right half alone, then an empty row.
		apply_setting(0, 1);
		for (int i = 0; i < 5; i++) send_byte(8'hFF, i == 4);
		for (int i = 0; i < BYTES_PER_ROW; i++) send_byte((i < 5) ? 8'h00 : 8'hFF, i == 9);
		for (int i = 0; i < BYTES_PER_ROW; i++) send_byte(8'h00, i == 9);

		// No rows analysed at all.
		apply_setting(150, 0);
		send_frame(25, PAT_DENSE);

		run_phase(0, 1, 50);
		run_phase(4680, 60, 50);
		run_phase(150, 2, 50);
		run_phase($urandom_range(0, 120), $urandom_range(1, 5), 50);
		for (int p = 0; p < 4; p++) run_phase(pick_threshold(), $urandom_range(1, 60), 50);

		// rows_used beyond the row limit acts as the row limit.
		calm = 1'b0;
		apply_setting(1000, 63);
		send_frame(3 * BYTES_PER_ROW, PAT_RIGHT);
		run_phase(pick_threshold(), 60, 40);

		wait_idle();
		repeat (10) @(negedge clk);
		$display("Checked %0d track results from %0d pixel bytes in %0d frames under %0d settings.",
			ledger.verdicts_seen, ledger.bytes_taken, frames_sent, settings_applied);
		$display("Field mismatches found: %0d.", ledger.mismatches);
		if (ledger.mismatches == 0 && ledger.due.size() == 0) begin
			$display("PASS binary_frame_track_classifier");
		end else begin
			$display("FAIL binary_frame_track_classifier");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Run timed out with %0d results outstanding.", ledger.due.size());
		$display("FAIL binary_frame_track_classifier");
		$finish;
	end

endmodule
